// File: design/blps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blps_pkg
// shared types and constants for the bounded push-front list with search
// ----------------------------------------------------------------------------
package blps_pkg;

	localparam int VALUE_W     = 32;
	localparam int CAP_W       = 6;
	localparam int REQ_W       = 3;
	localparam int POS_W       = 5;
	localparam int STATUS_W    = 2;
	localparam int ENTRY_IDX_W = 5;
	localparam int MATCH_W     = 6;
	localparam int DEPTH_DEF   = 32;
	localparam int CAP_RESET   = 32;

	localparam int IN_DATA_W   = 40;
	localparam int OUT_DATA_W  = 48;

	typedef enum logic [REQ_W-1:0] {
		REQ_ADD    = 3'd0,
		REQ_DEL    = 3'd1,
		REQ_SHOW   = 3'd2,
		REQ_SEARCH = 3'd3,
		REQ_MAX    = 3'd4,
		REQ_READ   = 3'd5
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_BAD_POS = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_PUSH = 2'd1,
		OP_POP  = 2'd2,
		OP_ROT  = 2'd3
	} chain_op_t;

	typedef struct packed {
		chain_op_t          op;
		logic [VALUE_W-1:0] push_data;
	} chain_ctrl_t;

endpackage
`default_nettype wire

// File: design/blps_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blps_cell
// one list entry: loads from a neighbour on push, pop or rotate
// ----------------------------------------------------------------------------
module blps_cell (
	input  wire                          clk,
	input  blps_pkg::chain_ctrl_t        ctrl,
	input  wire  [blps_pkg::VALUE_W-1:0] from_left,
	input  wire  [blps_pkg::VALUE_W-1:0] from_right,
	input  wire  [blps_pkg::VALUE_W-1:0] from_head,
	input  wire                          is_tail,
	output logic [blps_pkg::VALUE_W-1:0] value
);
	import blps_pkg::*;

	logic [VALUE_W-1:0] value_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_PUSH: value_q <= from_left;
			OP_POP:  value_q <= from_right;
			// tail wraps the head round so a full rotation restores order
			OP_ROT:  value_q <= is_tail ? from_head : from_right;
			default: value_q <= value_q;
		endcase
	end

	assign value = value_q;

endmodule
`default_nettype wire

// File: design/blps_chain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blps_chain
// row of list cells, front at cell 0
// ----------------------------------------------------------------------------
module blps_chain #(
	parameter int DEPTH = blps_pkg::DEPTH_DEF,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  wire                          clk,
	input  blps_pkg::chain_ctrl_t        ctrl,
	input  wire  [CNT_W-1:0]             count,
	output logic [blps_pkg::VALUE_W-1:0] head
);
	import blps_pkg::*;

	logic [VALUE_W-1:0] cell_val [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VALUE_W-1:0] left_in;
		logic [VALUE_W-1:0] right_in;
		logic               tail;

		if (i == 0) begin : g_first
			assign left_in = ctrl.push_data;
		end else begin : g_mid
			assign left_in = cell_val[i-1];
		end

		if (i == DEPTH - 1) begin : g_end
			assign right_in = cell_val[i];
		end else begin : g_inner
			assign right_in = cell_val[i+1];
		end

		assign tail = (CNT_W'(i + 1) == count);

		blps_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.from_left  (left_in),
			.from_right (right_in),
			.from_head  (cell_val[0]),
			.is_tail    (tail),
			.value      (cell_val[i])
		);
	end

	assign head = cell_val[0];

endmodule
`default_nettype wire

// File: design/bounded_list_push_front_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_list_push_front_search
// bounded stack of signed 32-bit values kept in a chain of cells, with
// show, search, maximum and positional read by rotating the chain
// ----------------------------------------------------------------------------
//
// channel   dir  handshake              payload
// s_axis    in   tvalid/tready          tdata: item_value, position; tuser: req_type
// m_axis    out  tvalid/tready          tdata: status, index, value, count; tlast
// cfg       in   cfg_we                 cfg_wdata: capacity (empties the list)
//
// add, delete, empty, full and bad-position requests give a single result and
// can follow back to back while the result register is drained.
// show, search, max and read rotate the chain once, search then adds a
// summary result, and afterwards the block returns to idle.
// a stalled result register freezes the rotation, so no result is lost.
// arst_n clears the count, capacity (to 32), state and result valid.
//
module bounded_list_push_front_search #(
	parameter int DEPTH = blps_pkg::DEPTH_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	// slave side
	input  wire                             s_axis_tvalid,
	output logic                            s_axis_tready,
	// item_value [31:0], position [36:32], zero pad [39:37]
	input  wire  [blps_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// req_type [2:0]
	input  wire  [blps_pkg::REQ_W-1:0]      s_axis_tuser,
	// master side
	output logic                            m_axis_tvalid,
	input  wire                             m_axis_tready,
	// status [1:0], entry_index [6:2], entry_value [38:7], match_count [44:39], zero [47:45]
	output logic [blps_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                            m_axis_tlast,
	// configuration
	input  wire                             cfg_we,
	input  wire  [blps_pkg::CAP_W-1:0]      cfg_wdata
);
	import blps_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SUM
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       count_q;
	logic [CAP_W-1:0]       cap_q;
	req_t                   req_q;
	logic [VALUE_W-1:0]     key_q;
	logic [POS_W-1:0]       pos_q;
	logic [CNT_W-1:0]       step_q;
	logic [MATCH_W-1:0]     hits_q;
	logic signed [VALUE_W-1:0] best_q;
	logic [CNT_W-1:0]       at_q;

	// result register
	logic                   out_valid_q;
	status_t                out_status_q;
	logic [ENTRY_IDX_W-1:0] out_index_q;
	logic [VALUE_W-1:0]     out_value_q;
	logic [MATCH_W-1:0]     out_match_q;
	logic                   out_last_q;

	logic                   out_free;
	logic                   in_xfer;
	req_t                   req_in;
	logic [VALUE_W-1:0]     value_in;
	logic [POS_W-1:0]       pos_in;
	logic [CAP_W-1:0]       limit;
	logic                   is_full;
	logic                   is_empty;
	logic                   req_known;
	logic [VALUE_W-1:0]     head;
	logic                   final_step;
	logic                   new_best;
	logic [MATCH_W-1:0]     hits_next;
	chain_ctrl_t            ctrl;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && out_free;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	assign req_in   = req_t'(s_axis_tuser);
	assign value_in = s_axis_tdata[VALUE_W-1:0];
	assign pos_in   = s_axis_tdata[VALUE_W +: POS_W];

	// capacity above the chain length is clamped to it
	assign limit     = (cap_q > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : cap_q;
	assign is_full   = CAP_W'(count_q) >= limit;
	assign is_empty  = (count_q == '0);
	assign req_known = (s_axis_tuser <= REQ_READ);

	// scan step bookkeeping, head of the chain is the entry at step_q
	assign final_step = (step_q + CNT_W'(1) == count_q);
	assign new_best   = (step_q == '0) || (best_q < $signed(head));
	assign hits_next  = hits_q + MATCH_W'(head == key_q);

	always_comb begin
		ctrl.op        = OP_HOLD;
		ctrl.push_data = value_in;
		if (in_xfer && req_in == REQ_ADD && !is_full) begin
			ctrl.op = OP_PUSH;
		end else if (in_xfer && req_in == REQ_DEL && !is_empty) begin
			ctrl.op = OP_POP;
		end else if (state_q == S_SCAN && out_free) begin
			ctrl.op = OP_ROT;
		end
	end

	blps_chain #(
		.DEPTH (DEPTH),
		.CNT_W (CNT_W)
	) u_chain (
		.clk   (clk),
		.ctrl  (ctrl),
		.count (count_q),
		.head  (head)
	);

	// control and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			cap_q       <= CAP_W'(CAP_RESET);
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				cap_q   <= cfg_wdata;
				count_q <= '0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_xfer && req_known) begin
						req_q        <= req_in;
						key_q        <= value_in;
						pos_q        <= pos_in;
						step_q       <= '0;
						hits_q       <= '0;
						out_valid_q  <= 1'b1;
						out_status_q <= ST_OK;
						out_index_q  <= '0;
						out_value_q  <= '0;
						out_match_q  <= '0;
						out_last_q   <= 1'b1;
						if (req_in == REQ_ADD) begin
							if (is_full) begin
								out_status_q <= ST_FULL;
							end else begin
								count_q     <= count_q + CNT_W'(1);
								out_value_q <= value_in;
							end
						end else if (is_empty) begin
							out_status_q <= ST_EMPTY;
						end else if (req_in == REQ_DEL) begin
							count_q     <= count_q - CNT_W'(1);
							out_value_q <= head;
						end else if (req_in == REQ_READ && CNT_W'(pos_in) >= count_q
							&& !(POS_W > CNT_W && (pos_in >> CNT_W) != '0)) begin
							out_status_q <= ST_BAD_POS;
						end else if (req_in == REQ_READ && POS_W > CNT_W
							&& (pos_in >> CNT_W) != '0) begin
							// position beyond what the count can hold
							out_status_q <= ST_BAD_POS;
						end else begin
							// scan requests: results come from the rotation
							out_valid_q <= 1'b0;
							state_q     <= S_SCAN;
						end
					end
				end

				S_SCAN: begin
					if (out_free) begin
						step_q      <= step_q + CNT_W'(1);
						hits_q      <= hits_next;
						if (new_best) begin
							best_q <= $signed(head);
							at_q   <= step_q;
						end
						out_status_q <= ST_OK;
						out_index_q  <= ENTRY_IDX_W'(step_q);
						out_value_q  <= head;
						out_match_q  <= '0;
						out_last_q   <= 1'b0;
						case (req_q)
							REQ_SHOW: begin
								out_valid_q <= 1'b1;
								out_last_q  <= final_step;
							end
							REQ_SEARCH: begin
								out_valid_q <= (head == key_q);
							end
							REQ_MAX: begin
								out_valid_q <= final_step;
								out_last_q  <= 1'b1;
								if (!new_best) begin
									out_index_q <= ENTRY_IDX_W'(at_q);
									out_value_q <= best_q;
								end
							end
							REQ_READ: begin
								out_valid_q <= (CNT_W'(pos_q) == step_q);
								out_last_q  <= 1'b1;
							end
							default: begin
								out_valid_q <= 1'b0;
							end
						endcase
						if (final_step) begin
							state_q <= (req_q == REQ_SEARCH) ? S_SUM : S_IDLE;
						end
					end
				end

				S_SUM: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= ST_OK;
						out_index_q  <= '0;
						out_value_q  <= key_q;
						out_match_q  <= hits_q;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {
		(OUT_DATA_W - STATUS_W - ENTRY_IDX_W - VALUE_W - MATCH_W)'(0),
		out_match_q,
		out_value_q,
		out_index_q,
		out_status_q
	};

endmodule
`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the bounded push-front list with search: a local
// model of the list predicts every result of each accepted request, and
// each result transfer is compared field by field with the oldest
// prediction, under random idling on both sides of the block
// ----------------------------------------------------------------------------
module testbench;

	import blps_pkg::*;

	localparam int LIST_MAX = 32;
	// request codes the block ignores
	localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;
	// cycles to let pass after the last result before the block counts as idle
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		status_t                st;
		logic [ENTRY_IDX_W-1:0] idx;
		logic [VALUE_W-1:0]     val;
		logic [MATCH_W-1:0]     hits;
		logic                   last;
	} list_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [REQ_W-1:0]      s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  cfg_we = 1'b0;
	logic [CAP_W-1:0]      cfg_wdata = '0;

	// model of the list, updated on every accepted transfer
	logic [VALUE_W-1:0] list_vals [0:LIST_MAX-1];
	int                 list_count = 0;
	int                 list_cap = CAP_RESET;
	list_result_t       awaited_results [$];
	list_result_t       oldest;

	int error_count = 0;
	int tx_idle_pct = 18;
	int rx_idle_pct = 77;

	// long receiver hold-off: the test bumps hold_id, the receiver serves it
	int hold_id = 0;
	int hold_len = 0;
	int hold_served = 0;
	int hold_left = 0;

	bounded_list_push_front_search u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// list model
	// ------------------------------------------------------------------------
	function automatic void push_result(status_t st, int idx, logic [VALUE_W-1:0] val,
			int hits, logic last);
		list_result_t r;
		r.st   = st;
		r.idx  = idx[ENTRY_IDX_W-1:0];
		r.val  = val;
		r.hits = hits[MATCH_W-1:0];
		r.last = last;
		awaited_results.push_back(r);
	endfunction

	// works out every result of one accepted request and updates the list
	function automatic void predict_request(logic [REQ_W-1:0] req, logic [VALUE_W-1:0] val,
			logic [POS_W-1:0] pos);
		int                 lim;
		int                 hits;
		int                 at;
		logic [VALUE_W-1:0] best;
		lim = (list_cap > LIST_MAX) ? LIST_MAX : list_cap;
		if (req == REQ_ADD) begin
			if (list_count >= lim) begin
				push_result(ST_FULL, 0, '0, 0, 1'b1);
			end else begin
				for (int i = list_count; i > 0; i--)
					list_vals[i] = list_vals[i-1];
				list_vals[0] = val;
				list_count++;
				push_result(ST_OK, 0, val, 0, 1'b1);
			end
		end else if (req == REQ_SPARE_LO || req == REQ_SPARE_HI) begin
			// ignored: no result, no change
		end else if (list_count == 0) begin
			push_result(ST_EMPTY, 0, '0, 0, 1'b1);
		end else begin
			case (req)
				REQ_DEL: begin
					push_result(ST_OK, 0, list_vals[0], 0, 1'b1);
					for (int i = 0; i + 1 < list_count; i++)
						list_vals[i] = list_vals[i+1];
					list_count--;
				end
				REQ_SHOW: begin
					for (int i = 0; i < list_count; i++)
						push_result(ST_OK, i, list_vals[i], 0, i + 1 == list_count);
				end
				REQ_SEARCH: begin
					hits = 0;
					for (int i = 0; i < list_count; i++) begin
						if (list_vals[i] == val) begin
							push_result(ST_OK, i, list_vals[i], 0, 1'b0);
							hits++;
						end
					end
					push_result(ST_OK, 0, val, hits, 1'b1);
				end
				REQ_MAX: begin
					best = list_vals[0];
					at = 0;
					for (int i = 1; i < list_count; i++) begin
						if ($signed(best) < $signed(list_vals[i])) begin
							best = list_vals[i];
							at = i;
						end
					end
					push_result(ST_OK, at, best, 0, 1'b1);
				end
				default: begin
					if (pos >= list_count)
						push_result(ST_BAD_POS, 0, '0, 0, 1'b1);
					else
						push_result(ST_OK, int'(pos), list_vals[pos], 0, 1'b1);
				end
			endcase
		end
	endfunction

	function automatic void check_field(string name, logic [VALUE_W-1:0] want,
			logic [VALUE_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endfunction

	// ------------------------------------------------------------------------
	// monitor: predicts on input transfers and checks output transfers,
	// both sampled at the rising edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				// capacity write empties the list
				list_cap = int'(cfg_wdata);
				list_count = 0;
				foreach (list_vals[i])
					list_vals[i] = '0;
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_request(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[36:32]);
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_results.size() == 0) begin
					$error("result transfer with nothing expected: tdata %0h", m_axis_tdata);
					error_count++;
				end else begin
					oldest = awaited_results.pop_front();
					check_field("status", VALUE_W'(oldest.st),
						VALUE_W'(m_axis_tdata[1:0]));
					check_field("entry_index", VALUE_W'(oldest.idx),
						VALUE_W'(m_axis_tdata[6:2]));
					check_field("entry_value", oldest.val, m_axis_tdata[38:7]);
					check_field("match_count", VALUE_W'(oldest.hits),
						VALUE_W'(m_axis_tdata[44:39]));
					check_field("last", VALUE_W'(oldest.last), VALUE_W'(m_axis_tlast));
				end
			end
		end
	end

	// receiver: random idling, plus a long hold-off when a test asks for one
	always @(negedge clk) begin
		if (hold_id != hold_served) begin
			hold_served = hold_id;
			hold_left = hold_len;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// ------------------------------------------------------------------------
	// shared tasks (all start and end just after a falling edge)
	// ------------------------------------------------------------------------
	task automatic send_request(logic [REQ_W-1:0] req, logic [VALUE_W-1:0] val,
			logic [POS_W-1:0] pos);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = req;
		s_axis_tdata  = {3'b000, pos, val};
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
	endtask

	// sender pauses until every expected result has come and the block is quiet
	task automatic drain_results();
		s_axis_tvalid = 1'b0;
		while (awaited_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] cap);
		drain_results();
		cfg_we    = 1'b1;
		cfg_wdata = cap;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		int v;
		case ($urandom_range(3))
			0: begin
				// small values so that searches find duplicates
				v = $urandom_range(4);
				return v - 2;
			end
			1: begin
				case ($urandom_range(3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// every request except add on a list that has never held anything
	task automatic test_empty_list();
		send_request(REQ_DEL, 32'h0, 5'd0);
		send_request(REQ_SHOW, 32'h0, 5'd0);
		send_request(REQ_SEARCH, 32'h1234_5678, 5'd0);
		send_request(REQ_MAX, 32'h0, 5'd0);
		send_request(REQ_READ, 32'h0, 5'd31);
		// unknown codes: no transfer out
		send_request(REQ_SPARE_LO, 32'hFFFF_FFFF, 5'd31);
		send_request(REQ_SPARE_HI, 32'h0, 5'd0);
		drain_results();
	endtask

	// small capacity, extreme values, full and out-of-range cases
	task automatic test_small_list();
		write_capacity(6'd2);
		send_request(REQ_ADD, 32'h7FFF_FFFF, 5'd0);
		send_request(REQ_ADD, 32'h8000_0000, 5'd31);
		send_request(REQ_ADD, 32'h0000_0005, 5'd0);
		send_request(REQ_SHOW, 32'h0, 5'd0);
		send_request(REQ_SEARCH, 32'h8000_0000, 5'd0);
		send_request(REQ_SEARCH, 32'h0000_0001, 5'd0);
		send_request(REQ_MAX, 32'h0, 5'd0);
		send_request(REQ_READ, 32'h0, 5'd1);
		send_request(REQ_READ, 32'h0, 5'd2);
		send_request(REQ_DEL, 32'h0, 5'd0);
		send_request(REQ_DEL, 32'h0, 5'd0);
		send_request(REQ_DEL, 32'h0, 5'd0);
		drain_results();
	endtask

	// zero capacity refuses every add; above the depth it is clamped
	task automatic test_capacity_extremes();
		write_capacity(6'd0);
		send_request(REQ_ADD, 32'h0000_0001, 5'd0);
		send_request(REQ_SHOW, 32'h0, 5'd0);
		write_capacity(6'd63);
		send_request(REQ_ADD, 32'hFFFF_FFFF, 5'd0);
		send_request(REQ_MAX, 32'h0, 5'd0);
		drain_results();
	endtask

	// mixed random requests, add-heavy so the list gets deep
	task automatic test_random_traffic(int tx_pct, int rx_pct, logic [CAP_W-1:0] cap,
			int n_req);
		int                 sent;
		int                 r;
		logic [VALUE_W-1:0] key;
		logic [POS_W-1:0]   pos;
		write_capacity(cap);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		sent = 0;
		while (sent < n_req) begin
			r = $urandom_range(99);
			if (r < 45) begin
				send_request(REQ_ADD, pick_value(), POS_W'($urandom_range(31)));
			end else if (r < 55) begin
				send_request(REQ_DEL, $urandom, POS_W'($urandom_range(31)));
			end else if (r < 63) begin
				send_request(REQ_SHOW, $urandom, POS_W'($urandom_range(31)));
			end else if (r < 77) begin
				// mostly keys that are in the list
				if (list_count > 0 && $urandom_range(99) < 60)
					key = list_vals[POS_W'($urandom_range(list_count - 1))];
				else
					key = pick_value();
				send_request(REQ_SEARCH, key, POS_W'($urandom_range(31)));
			end else if (r < 85) begin
				send_request(REQ_MAX, $urandom, POS_W'($urandom_range(31)));
			end else if (r < 96) begin
				if (list_count > 0 && $urandom_range(99) < 70)
					pos = POS_W'($urandom_range(list_count - 1));
				else
					pos = POS_W'($urandom_range(31));
				send_request(REQ_READ, $urandom, pos);
			end else begin
				// ignored codes do not count
				send_request($urandom_range(1) ? REQ_SPARE_HI : REQ_SPARE_LO, $urandom,
					POS_W'($urandom_range(31)));
				sent--;
			end
			sent++;
		end
		drain_results();
	endtask

	// receiver holds off for a long stretch while the sender keeps offering
	task automatic test_backpressure();
		write_capacity(6'd32);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_len = 400;
		hold_id++;
		for (int i = 0; i < 8; i++)
			send_request(REQ_ADD, $urandom, 5'd0);
		send_request(REQ_SHOW, 32'h0, 5'd0);
		send_request(REQ_SEARCH, list_vals[3], 5'd0);
		send_request(REQ_MAX, 32'h0, 5'd0);
		send_request(REQ_DEL, 32'h0, 5'd0);
		drain_results();
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_empty_list();
		test_small_list();
		test_capacity_extremes();
		test_random_traffic(18, 77, 6'd32, 35);
		test_random_traffic(77, 18, 6'd63, 30);
		test_random_traffic(0, 0, 6'd3, 30);
		test_random_traffic(0, 0, 6'd20, 35);
		test_backpressure();
		if (awaited_results.size() != 0) begin
			$error("%0d expected results never arrived", awaited_results.size());
			error_count++;
		end
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#3_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
